>>> hdl/ray_plane_intersect_macros.svh
// Assertion macros shared by the ray-plane intersection RTL.
`ifndef RAY_PLANE_INTERSECT_MACROS_SVH
`define RAY_PLANE_INTERSECT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define RPI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define RPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/rpi_pkg.sv
// Shared constants and payload types of the ray-plane intersection pipeline.
`default_nettype none

package rpi_pkg;

   // Coordinate format: signed fixed point
   localparam int CoordWidth     = 32;
   localparam int FracBits       = 16;
   localparam int ThresholdWidth = 32;

   // Derived arithmetic widths
   localparam int DiffWidth  = CoordWidth + 1;          // plane point minus origin
   localparam int DProdWidth = 2 * CoordWidth;          // one coordinate product
   localparam int DSumWidth  = 2 * CoordWidth + 2;      // direction . normal
   localparam int DMagWidth  = 2 * CoordWidth;          // |direction . normal|
   localparam int NProdWidth = 2 * CoordWidth + 1;      // diff * normal
   localparam int NSumWidth  = 2 * CoordWidth + 3;      // numerator dot product
   localparam int NMagWidth  = 2 * CoordWidth + 1;      // |numerator|
   localparam int RemWidth   = NMagWidth + FracBits;    // scaled numerator / remainder
   localparam int QuotBits   = CoordWidth;              // quotient bits kept
   localparam int ShiftWidth = DMagWidth + QuotBits;    // divisor aligned to top quotient bit
   localparam int PointWidth = DProdWidth - FracBits + 1;

   localparam logic [ThresholdWidth-1:0] ThresholdReset = ThresholdWidth'(4295);

   localparam logic [CoordWidth-1:0] CoordMax = {1'b0, {(CoordWidth-1){1'b1}}};
   localparam logic [CoordWidth-1:0] CoordMin = {1'b1, {(CoordWidth-1){1'b0}}};

   // Input item
   typedef struct packed {
      logic signed [CoordWidth-1:0] origin_x;
      logic signed [CoordWidth-1:0] origin_y;
      logic signed [CoordWidth-1:0] origin_z;
      logic signed [CoordWidth-1:0] dir_x;
      logic signed [CoordWidth-1:0] dir_y;
      logic signed [CoordWidth-1:0] dir_z;
      logic signed [CoordWidth-1:0] plane_point_x;
      logic signed [CoordWidth-1:0] plane_point_y;
      logic signed [CoordWidth-1:0] plane_point_z;
      logic signed [CoordWidth-1:0] normal_x;
      logic signed [CoordWidth-1:0] normal_y;
      logic signed [CoordWidth-1:0] normal_z;
   } req_payload_type;

   // Result item
   typedef struct packed {
      logic                         hit;
      logic signed [CoordWidth-1:0] point_x;
      logic signed [CoordWidth-1:0] point_y;
      logic signed [CoordWidth-1:0] point_z;
      logic                         saturated;
   } rsp_payload_type;

   // Item as it moves through the divider stages
   typedef struct packed {
      logic [RemWidth-1:0]              rem;    // partial remainder
      logic [QuotBits-1:0]              quot;   // quotient magnitude, built MSB first
      logic [DMagWidth-1:0]             dmag;   // divisor |direction . normal|
      logic                             neg;    // quotient sign
      logic                             ovf;    // quotient needs more than QuotBits bits
      logic                             par;    // ray parallel to plane
      logic [2:0][CoordWidth-1:0]       dir;
      logic [2:0][CoordWidth-1:0]       org;
   } div_data_type;

endpackage

`default_nettype wire

>>> hdl/rpi_front.sv
// Front pipeline: dot products, parallel test and divider set-up (four stages).
`default_nettype none
`include "ray_plane_intersect_macros.svh"

module rpi_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [rpi_pkg::ThresholdWidth-1:0]     threshold,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  rpi_pkg::req_payload_type               in_data,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output rpi_pkg::div_data_type                  out_data
);
   import rpi_pkg::*;

   localparam int Stages = 4;
   localparam int Last   = Stages - 1;

   typedef struct packed {
      logic [2:0][DiffWidth-1:0]  diff;
      logic [2:0][DProdWidth-1:0] dprod;
      logic [2:0][CoordWidth-1:0] dir;
      logic [2:0][CoordWidth-1:0] org;
      logic [2:0][CoordWidth-1:0] nrm;
   } s1_type;

   typedef struct packed {
      logic [2:0][NProdWidth-1:0] nprod;
      logic [DSumWidth-1:0]       dsum;
      logic [2:0][CoordWidth-1:0] dir;
      logic [2:0][CoordWidth-1:0] org;
   } s2_type;

   typedef struct packed {
      logic [NSumWidth-1:0]       nsum;
      logic [DMagWidth-1:0]       dmag;
      logic                       dneg;
      logic                       par;
      logic [2:0][CoordWidth-1:0] dir;
      logic [2:0][CoordWidth-1:0] org;
   } s3_type;

   logic [Stages-1:0] valid_ff, valid_in, adv, src_valid;
   s1_type            s1_ff, s1_in;
   s2_type            s2_ff, s2_in;
   s3_type            s3_ff, s3_in;
   div_data_type      s4_ff, s4_in;

   // A stage moves when the output is taken or some stage at or after it is empty
   always_comb begin
      for (int k = 0; k < Stages; k++) begin
         adv[k] = out_ready || ((valid_ff >> k) != ({Stages{1'b1}} >> k));
      end
      src_valid = {valid_ff[Stages-2:0], in_valid};
      for (int k = 0; k < Stages; k++) begin
         valid_in[k] = adv[k] ? src_valid[k] : valid_ff[k];
      end
   end

   // Stage 1: coordinate differences and direction x normal products
   always_comb begin
      s1_in.dir = {in_data.dir_z, in_data.dir_y, in_data.dir_x};
      s1_in.org = {in_data.origin_z, in_data.origin_y, in_data.origin_x};
      s1_in.nrm = {in_data.normal_z, in_data.normal_y, in_data.normal_x};
      s1_in.diff[0] = DiffWidth'(in_data.plane_point_x) - DiffWidth'(in_data.origin_x);
      s1_in.diff[1] = DiffWidth'(in_data.plane_point_y) - DiffWidth'(in_data.origin_y);
      s1_in.diff[2] = DiffWidth'(in_data.plane_point_z) - DiffWidth'(in_data.origin_z);
      for (int i = 0; i < 3; i++) begin
         s1_in.dprod[i] = DProdWidth'($signed(s1_in.dir[i]))
                        * DProdWidth'($signed(s1_in.nrm[i]));
      end
   end

   // Stage 2: numerator products, denominator sum
   always_comb begin
      s2_in.dir = s1_ff.dir;
      s2_in.org = s1_ff.org;
      for (int i = 0; i < 3; i++) begin
         s2_in.nprod[i] = NProdWidth'($signed(s1_ff.diff[i]))
                        * NProdWidth'($signed(s1_ff.nrm[i]));
      end
      s2_in.dsum = DSumWidth'($signed(s1_ff.dprod[0]))
                 + DSumWidth'($signed(s1_ff.dprod[1]))
                 + DSumWidth'($signed(s1_ff.dprod[2]));
   end

   // Stage 3: numerator sum, denominator magnitude and parallel test
   always_comb begin
      logic [DSumWidth-1:0] dabs;
      s3_in.dir  = s2_ff.dir;
      s3_in.org  = s2_ff.org;
      s3_in.nsum = NSumWidth'($signed(s2_ff.nprod[0]))
                 + NSumWidth'($signed(s2_ff.nprod[1]))
                 + NSumWidth'($signed(s2_ff.nprod[2]));
      s3_in.dneg = s2_ff.dsum[DSumWidth-1];
      dabs       = s3_in.dneg ? -s2_ff.dsum : s2_ff.dsum;
      s3_in.dmag = dabs[DMagWidth-1:0];
      // zero always counts as parallel, even with a zero threshold
      s3_in.par  = (s3_in.dmag == '0) || (s3_in.dmag < DMagWidth'(threshold));
   end

   // Stage 4: scaled numerator magnitude, quotient sign and range check
   always_comb begin
      logic [NSumWidth-1:0] nabs;
      logic                 nneg;
      nneg        = s3_ff.nsum[NSumWidth-1];
      nabs        = nneg ? -s3_ff.nsum : s3_ff.nsum;
      s4_in.rem   = {nabs[NMagWidth-1:0], {FracBits{1'b0}}};
      s4_in.quot  = '0;
      s4_in.dmag  = s3_ff.dmag;
      s4_in.neg   = nneg ^ s3_ff.dneg;
      s4_in.ovf   = ShiftWidth'(s4_in.rem) >= {s3_ff.dmag, {QuotBits{1'b0}}};
      s4_in.par   = s3_ff.par;
      s4_in.dir   = s3_ff.dir;
      s4_in.org   = s3_ff.org;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_ff <= s1_in;
      end
      if (adv[1]) begin
         s2_ff <= s2_in;
      end
      if (adv[2]) begin
         s3_ff <= s3_in;
      end
      if (adv[3]) begin
         s4_ff <= s4_in;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[Last];
   assign out_data  = s4_ff;

   `RPI_ASSERT_IMPL(a_front_empty_takes, clock, reset, !valid_ff[0], in_ready, "front stage empty but input stalled")
   `RPI_ASSERT_NEXT(a_front_holds_item, clock, reset, valid_ff[Last] && !out_ready, valid_ff[Last], "front dropped a stalled item")

endmodule

`default_nettype wire

>>> hdl/rpi_divider.sv
// Pipelined restoring divider: one quotient bit per register stage.
`default_nettype none
`include "ray_plane_intersect_macros.svh"

module rpi_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rpi_pkg::div_data_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rpi_pkg::div_data_type out_data
);
   import rpi_pkg::*;

   localparam int Stages = QuotBits;

   logic [Stages-1:0] valid_ff, valid_in, adv, src_valid;
   div_data_type      data_ff [Stages];
   div_data_type      data_in [Stages];
   div_data_type      src     [Stages];

   // Stage handshake: move when the output is taken or some stage at or after it is empty
   always_comb begin
      for (int k = 0; k < Stages; k++) begin
         adv[k] = out_ready || ((valid_ff >> k) != ({Stages{1'b1}} >> k));
      end
      src_valid = {valid_ff[Stages-2:0], in_valid};
      for (int k = 0; k < Stages; k++) begin
         valid_in[k] = adv[k] ? src_valid[k] : valid_ff[k];
      end
   end

   // Stage k decides quotient bit Stages-1-k: subtract the aligned divisor if it fits
   always_comb begin
      logic [ShiftWidth-1:0] shifted;
      logic [ShiftWidth-1:0] rext;
      src[0] = in_data;
      for (int k = 1; k < Stages; k++) begin
         src[k] = data_ff[k-1];
      end
      for (int k = 0; k < Stages; k++) begin
         data_in[k] = src[k];
         shifted    = ShiftWidth'(src[k].dmag) << (Stages - 1 - k);
         rext       = ShiftWidth'(src[k].rem);
         if (rext >= shifted) begin
            data_in[k].rem                 = RemWidth'(rext - shifted);
            data_in[k].quot[Stages - 1 - k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < Stages; k++) begin
         if (adv[k]) begin
            data_ff[k] <= data_in[k];
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[Stages-1];
   assign out_data  = data_ff[Stages-1];

   // a finished in-range division leaves a remainder below the divisor
   `RPI_ASSERT_IMPL(a_div_rem_bound, clock, reset, out_valid && !out_data.ovf && !out_data.par, ShiftWidth'(out_data.rem) < ShiftWidth'(out_data.dmag), "divider remainder not below divisor")

endmodule

`default_nettype wire

>>> hdl/rpi_back.sv
// Back pipeline: clamp t, scale the direction and form the saturated hit point.
`default_nettype none
`include "ray_plane_intersect_macros.svh"

module rpi_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  rpi_pkg::div_data_type    in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rpi_pkg::rsp_payload_type out_data
);
   import rpi_pkg::*;

   localparam int Stages = 3;

   typedef struct packed {
      logic [CoordWidth-1:0]      t;
      logic                       tflag;
      logic                       hit;
      logic [2:0][CoordWidth-1:0] dir;
      logic [2:0][CoordWidth-1:0] org;
   } b1_type;

   typedef struct packed {
      logic [2:0][DProdWidth-1:0] prod;
      logic                       tflag;
      logic                       hit;
      logic [2:0][CoordWidth-1:0] org;
   } b2_type;

   logic [Stages-1:0] valid_ff, valid_in, adv, src_valid;
   b1_type            b1_ff, b1_in;
   b2_type            b2_ff, b2_in;
   rsp_payload_type   b3_ff, b3_in;

   // Stage handshake; the last stage is the output register
   always_comb begin
      for (int k = 0; k < Stages; k++) begin
         adv[k] = out_ready || ((valid_ff >> k) != ({Stages{1'b1}} >> k));
      end
      src_valid = {valid_ff[Stages-2:0], in_valid};
      for (int k = 0; k < Stages; k++) begin
         valid_in[k] = adv[k] ? src_valid[k] : valid_ff[k];
      end
   end

   // Stage 1: apply the sign to the quotient and clamp t to the coordinate range
   always_comb begin
      logic [QuotBits-1:0] q;
      q           = in_data.quot;
      b1_in.dir   = in_data.dir;
      b1_in.org   = in_data.org;
      b1_in.hit   = !in_data.par;
      b1_in.tflag = 1'b0;
      if (in_data.ovf) begin
         b1_in.t     = in_data.neg ? CoordMin : CoordMax;
         b1_in.tflag = 1'b1;
      end else if (in_data.neg) begin
         if (q[QuotBits-1] && (|q[QuotBits-2:0])) begin
            b1_in.t     = CoordMin;
            b1_in.tflag = 1'b1;
         end else begin
            b1_in.t = -q;
         end
      end else if (q[QuotBits-1]) begin
         b1_in.t     = CoordMax;
         b1_in.tflag = 1'b1;
      end else begin
         b1_in.t = q;
      end
   end

   // Stage 2: direction times t, one multiplier per axis
   always_comb begin
      b2_in.tflag = b1_ff.tflag;
      b2_in.hit   = b1_ff.hit;
      b2_in.org   = b1_ff.org;
      for (int i = 0; i < 3; i++) begin
         b2_in.prod[i] = DProdWidth'($signed(b1_ff.dir[i]))
                       * DProdWidth'($signed(b1_ff.t));
      end
   end

   // Stage 3: drop fraction bits (floor), add origin, saturate; zero on a miss
   always_comb begin
      logic signed [PointWidth-1:0] sum;
      logic [2:0][CoordWidth-1:0]   pt;
      logic [2:0]                   clamp;
      for (int i = 0; i < 3; i++) begin
         sum = PointWidth'($signed(b2_ff.prod[i][DProdWidth-1:FracBits]))
             + PointWidth'($signed(b2_ff.org[i]));
         if ((&sum[PointWidth-1:CoordWidth-1]) || !(|sum[PointWidth-1:CoordWidth-1])) begin
            pt[i]    = sum[CoordWidth-1:0];
            clamp[i] = 1'b0;
         end else begin
            pt[i]    = sum[PointWidth-1] ? CoordMin : CoordMax;
            clamp[i] = 1'b1;
         end
      end
      b3_in.hit       = b2_ff.hit;
      b3_in.point_x   = b2_ff.hit ? pt[0] : '0;
      b3_in.point_y   = b2_ff.hit ? pt[1] : '0;
      b3_in.point_z   = b2_ff.hit ? pt[2] : '0;
      b3_in.saturated = b2_ff.hit && (b2_ff.tflag || (|clamp));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         b1_ff <= b1_in;
      end
      if (adv[1]) begin
         b2_ff <= b2_in;
      end
      if (adv[2]) begin
         b3_ff <= b3_in;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[Stages-1];
   assign out_data  = b3_ff;

   `RPI_ASSERT_IMPL(a_back_miss_is_zero, clock, reset, out_valid && !out_data.hit, out_data.point_x == '0 && out_data.point_y == '0 && out_data.point_z == '0 && !out_data.saturated, "parallel result not cleared")

endmodule

`default_nettype wire

>>> hdl/ray_plane_intersect.sv
// Top level of the ray-plane intersection pipeline with its APB register port.
//
//  channel | ports                                          | role
//  --------+------------------------------------------------+------------------------------
//  req     | req_valid, req_stall, req_data                 | ray and plane in
//  rsp     | rsp_valid, rsp_stall, rsp_data                 | hit flag and point out
//  csr     | psel, penable, pwrite, paddr, pwdata, prdata,  | parallel_threshold at 0x0
//          | pready                                         |
//
// One transfer per cycle sustained while rsp_stall is low; 39 register stages
// from req_data to rsp_data: 4 front stages, 32 divider stages (one quotient
// bit each) and 3 back stages.
// Reset empties every stage and sets parallel_threshold to 4295.
// rsp_stall holds the output register; items behind it keep moving into empty
// stages, and req_stall rises only when every stage holds an item.
`default_nettype none

module ray_plane_intersect (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rpi_pkg::req_payload_type            req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rpi_pkg::rsp_payload_type            rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [2:0]                          paddr,
   input  logic [rpi_pkg::ThresholdWidth-1:0]  pwdata,
   output logic [rpi_pkg::ThresholdWidth-1:0]  prdata,
   output logic                                pready
);
   import rpi_pkg::*;

   localparam int   CsrAddrWidth    = 3;
   localparam logic CsrIdxThreshold = 1'b0;

   logic [ThresholdWidth-1:0] thr_ff, thr_in;
   logic                      thr_sel;

   logic         front_ready, div_in_ready, div_out_valid, back_ready, front_valid;
   div_data_type front_data, div_data;

   // Register port: word index sits above the byte offset
   assign thr_sel = (paddr[CsrAddrWidth-1] == CsrIdxThreshold);
   assign pready  = 1'b1;
   assign prdata  = thr_sel ? thr_ff : '0;

   always_comb begin
      thr_in = thr_ff;
      if (psel && penable && pwrite && thr_sel) begin
         thr_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ThresholdReset;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign req_stall = !front_ready;

   rpi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .threshold (thr_ff),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_ready (div_in_ready),
      .out_data  (front_data)
   );

   rpi_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (div_in_ready),
      .in_data   (front_data),
      .out_valid (div_out_valid),
      .out_ready (back_ready),
      .out_data  (div_data)
   );

   rpi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_out_valid),
      .in_ready  (back_ready),
      .in_data   (div_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> sim/tb_ray_plane_intersect.sv
// Testbench for ray_plane_intersect: directed and random rays checked by a Q16.16 scoreboard.
`timescale 1ns / 100ps

module tb_ray_plane_intersect;
   import rpi_pkg::*;

   localparam logic [2:0]            ThresholdAddr = 3'd0;
   localparam logic signed [31:0]    OneQ          = 32'sh0001_0000;
   localparam int                    DrainCycles   = 60;
   localparam int                    HoldCycles    = 400;
   localparam int                    WatchdogLimit = 3000;
   localparam int                    PhaseItems    = 110;

   // Expected intersection results, predicted from each accepted ray
   class hit_point_tracker;
      logic [ThresholdWidth-1:0] limit = ThresholdReset;
      rsp_payload_type           pending_points[$];
      int                        fails = 0;

      // Clamp a wide value to the coordinate range, noting any clamp
      function logic signed [127:0] clamp_coord(logic signed [127:0] v, inout bit flag);
         logic signed [127:0] hi_lim;
         logic signed [127:0] lo_lim;
         hi_lim = CoordMax;
         lo_lim = $signed(CoordMin);
         if (v > hi_lim) begin
            flag = 1'b1;
            return hi_lim;
         end
         if (v < lo_lim) begin
            flag = 1'b1;
            return lo_lim;
         end
         return v;
      endfunction

      function rsp_payload_type predict_hit(req_payload_type r);
         logic signed [127:0] org[3], dv[3], pp[3], nv[3], pt[3];
         logic signed [127:0] dot_dn, dot_num, t_val;
         logic [127:0]        dn_mag, num_mag, quo;
         bit                  clamp, flip;
         rsp_payload_type     res;
         org[0] = r.origin_x;      org[1] = r.origin_y;      org[2] = r.origin_z;
         dv[0]  = r.dir_x;         dv[1]  = r.dir_y;         dv[2]  = r.dir_z;
         pp[0]  = r.plane_point_x; pp[1]  = r.plane_point_y; pp[2]  = r.plane_point_z;
         nv[0]  = r.normal_x;      nv[1]  = r.normal_y;      nv[2]  = r.normal_z;
         res = '0;
         // direction . normal, exact; zero always counts as parallel
         dot_dn = dv[0] * nv[0] + dv[1] * nv[1] + dv[2] * nv[2];
         dn_mag = (dot_dn < 0) ? -dot_dn : dot_dn;
         if (dn_mag == 0 || dn_mag < limit)
            return res;
         // t = (numerator << frac) / d, truncated toward zero
         dot_num = (pp[0] - org[0]) * nv[0] + (pp[1] - org[1]) * nv[1]
                 + (pp[2] - org[2]) * nv[2];
         flip    = (dot_num < 0) != (dot_dn < 0);
         num_mag = (dot_num < 0) ? -dot_num : dot_num;
         quo     = (num_mag << FracBits) / dn_mag;
         clamp   = 1'b0;
         t_val   = flip ? -$signed(quo) : $signed(quo);
         t_val   = clamp_coord(t_val, clamp);
         // point = origin + (dir * t) >>> frac, each coordinate saturated
         for (int i = 0; i < 3; i++)
            pt[i] = clamp_coord(((dv[i] * t_val) >>> FracBits) + org[i], clamp);
         res.hit       = 1'b1;
         res.point_x   = pt[0][CoordWidth-1:0];
         res.point_y   = pt[1][CoordWidth-1:0];
         res.point_z   = pt[2][CoordWidth-1:0];
         res.saturated = clamp;
         return res;
      endfunction

      function void note_ray(req_payload_type r);
         pending_points.push_back(predict_hit(r));
      endfunction

      function void check_point(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_points.size() == 0) begin
            $error("result transfer with no ray outstanding: %h", got);
            fails++;
            return;
         end
         want = pending_points.pop_front();
         if (got.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, got.hit);
            fails++;
         end
         if (got.point_x !== want.point_x) begin
            $error("point_x: expected %0d, got %0d", want.point_x, got.point_x);
            fails++;
         end
         if (got.point_y !== want.point_y) begin
            $error("point_y: expected %0d, got %0d", want.point_y, got.point_y);
            fails++;
         end
         if (got.point_z !== want.point_z) begin
            $error("point_z: expected %0d, got %0d", want.point_z, got.point_z);
            fails++;
         end
         if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
            fails++;
         end
      endfunction
   endclass

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_payload_type           req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_payload_type           rsp_data;
   logic                      psel      = 1'b0;
   logic                      penable   = 1'b0;
   logic                      pwrite    = 1'b0;
   logic [2:0]                paddr     = '0;
   logic [ThresholdWidth-1:0] pwdata    = '0;
   logic [ThresholdWidth-1:0] prdata;
   logic                      pready;

   hit_point_tracker tracker;
   int               hold_len    = 0;
   int               idle_cycles = 0;
   bit               send_burst  = 1'b0;
   bit               take_burst  = 1'b0;

   ray_plane_intersect u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // Idle length per item; occasionally flips into or out of a burst with no idling
   function automatic int draw_gap(inout bit burst);
      if ($urandom_range(0, 31) == 0)
         burst = !burst;
      return burst ? 0 : $urandom_range(0, 13);
   endfunction

   // Signed value in [-2^bits, 2^bits - 1]
   function automatic logic signed [31:0] rand_span(int bits);
      logic signed [31:0] raw;
      raw = $urandom;
      return raw >>> (31 - bits);
   endfunction

   function automatic logic [31:0] pick_edge();
      unique case ($urandom_range(0, 5))
         0: return CoordMax;
         1: return CoordMin;
         2: return '0;
         3: return 32'd1;
         4: return '1;
         default: return OneQ;
      endcase
   endfunction

   function automatic req_payload_type ray_of(
      logic signed [31:0] ox, oy, oz, dx, dy, dz, px, py, pz, nx, ny, nz);
      req_payload_type r;
      r.origin_x = ox;      r.origin_y = oy;      r.origin_z = oz;
      r.dir_x = dx;         r.dir_y = dy;         r.dir_z = dz;
      r.plane_point_x = px; r.plane_point_y = py; r.plane_point_z = pz;
      r.normal_x = nx;      r.normal_y = ny;      r.normal_z = nz;
      return r;
   endfunction

   // Offer one ray after an optional gap; returns at the transfer edge
   task automatic send_ray(input req_payload_type item, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering and wait until every expected result has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending_points.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Write the threshold register, then read it back
   task automatic program_threshold(input logic [ThresholdWidth-1:0] value);
      logic [ThresholdWidth-1:0] seen;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ThresholdAddr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      seen = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      tracker.limit = value;
      if (seen !== value) begin
         $error("parallel_threshold: expected %0d, got %0d", value, seen);
         tracker.fails++;
      end
   endtask

   // Transfer monitors on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.note_ray(req_data);
         if (rsp_valid && !rsp_stall)
            tracker.check_point(rsp_data);
      end
   end

   // Watchdog: cycles in a row with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchdogLimit) begin
         $display("ray_plane_intersect: mismatch");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold when requested
   initial begin : take_results
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = (hold_len > 0) ? hold_len : draw_gap(take_burst);
         hold_len = 0;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : main_flow
      req_payload_type           ray;
      logic [ThresholdWidth-1:0] phase_limits[5];
      longint                    tgt;
      int                        kind;

      tracker = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rays at the reset threshold
      send_ray(ray_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), draw_gap(send_burst));
      send_ray(ray_of(0, 0, 0, 0, 0, OneQ, 0, 0, 5 * OneQ, 0, 0, OneQ),
               draw_gap(send_burst));
      // plane behind the ray: negative t
      send_ray(ray_of(OneQ, 2 * OneQ, 3 * OneQ, 0, 0, -OneQ, 0, 0, 5 * OneQ, 0, 0, OneQ),
               draw_gap(send_burst));
      // origin on the plane: t is zero
      send_ray(ray_of(0, 0, 5 * OneQ, OneQ, OneQ, OneQ, 7 * OneQ, 8 * OneQ, 5 * OneQ,
                      0, 0, OneQ), draw_gap(send_burst));
      // dot product just under, at, and negative at the threshold
      send_ray(ray_of(0, 0, 0, 4294, 0, 0, OneQ, 0, 0, 1, 0, 0), draw_gap(send_burst));
      send_ray(ray_of(0, 0, 0, 4295, 0, 0, OneQ, 0, 0, 1, 0, 0), draw_gap(send_burst));
      send_ray(ray_of(0, 0, 0, -4295, 0, 0, OneQ, 0, 0, 1, 0, 0), draw_gap(send_burst));
      // t clamps
      send_ray(ray_of(CoordMin, 0, 0, 4295, 0, 0, CoordMax, 0, 0, 1, 0, 0),
               draw_gap(send_burst));
      // point clamps high in y and low in z
      send_ray(ray_of(0, CoordMax, CoordMin, OneQ, OneQ, -OneQ, 10 * OneQ, 0, 0,
                      OneQ, 0, 0), draw_gap(send_burst));
      send_ray(ray_of(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax,
                      CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax),
               draw_gap(send_burst));
      send_ray(ray_of(CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin,
                      CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin),
               draw_gap(send_burst));
      send_ray(ray_of(CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin,
                      CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax),
               draw_gap(send_burst));
      // largest dot product
      send_ray(ray_of(0, 0, 0, CoordMin, CoordMin, CoordMin, OneQ, OneQ, OneQ,
                      CoordMin, CoordMin, CoordMin), draw_gap(send_burst));
      settle();

      // Zero threshold: smallest nonzero dot product hits, zero still parallel
      program_threshold('0);
      send_ray(ray_of(0, 0, 0, 1, 0, 0, OneQ, 0, 0, 1, 0, 0), draw_gap(send_burst));
      send_ray(ray_of(0, 0, 0, OneQ, 0, 0, OneQ, 0, 0, 0, OneQ, 0), draw_gap(send_burst));
      settle();

      // Full threshold: one below stays parallel, equal hits in either sign
      program_threshold('1);
      send_ray(ray_of(0, 0, 0, 2, 0, 0, OneQ, 0, 0, CoordMax, 0, 0), draw_gap(send_burst));
      send_ray(ray_of(0, 0, 0, 32'hFFFF, 0, 0, OneQ, 0, 0, 32'h10001, 0, 0),
               draw_gap(send_burst));
      send_ray(ray_of(0, 0, 0, -32'sh0000_FFFF, 0, 0, OneQ, 0, 0, 32'h10001, 0, 0),
               draw_gap(send_burst));
      settle();

      // Back-pressure: long result hold while rays keep coming
      program_threshold(ThresholdReset);
      hold_len = HoldCycles;
      for (int n = 0; n < 80; n++) begin
         for (int k = 0; k < 12; k++)
            ray[k*32 +: 32] = rand_span(24);
         send_ray(ray, 0);
      end

      phase_limits[0] = ThresholdReset;
      phase_limits[1] = '0;
      phase_limits[2] = '1;
      phase_limits[3] = $urandom;
      phase_limits[4] = $urandom_range(1, 100000);

      // Random phases, one threshold each
      for (int p = 0; p < 5; p++) begin
         settle();
         program_threshold(phase_limits[p]);
         for (int n = 0; n < PhaseItems; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
               // scene-sized geometry: short direction and normal words
               for (int k = 0; k < 12; k++)
                  ray[k*32 +: 32] = ((k < 3) || (k >= 6 && k < 9)) ? rand_span(17)
                                                                   : rand_span(26);
            end else if (kind < 60) begin
               for (int k = 0; k < 12; k++)
                  ray[k*32 +: 32] = $urandom;
            end else if (kind < 75) begin
               // dot product within two of the threshold
               for (int k = 0; k < 12; k++)
                  ray[k*32 +: 32] = rand_span(24);
               tgt = longint'(tracker.limit) + longint'($urandom_range(0, 4)) - 2;
               if (tgt < 0)
                  tgt = 0;
               ray.dir_x    = 4;
               ray.normal_x = 32'(tgt >> 2);
               ray.dir_y    = 1;
               ray.normal_y = 32'(tgt & 3);
               ray.normal_z = 0;
               if ($urandom_range(0, 1)) begin
                  ray.dir_x = -ray.dir_x;
                  ray.dir_y = -ray.dir_y;
               end
            end else if (kind < 88) begin
               for (int k = 0; k < 12; k++)
                  ray[k*32 +: 32] = pick_edge();
            end else begin
               // normal perpendicular to direction: exactly parallel
               for (int k = 0; k < 12; k++)
                  ray[k*32 +: 32] = rand_span(20);
               ray.normal_x = -ray.dir_y;
               ray.normal_y = ray.dir_x;
               ray.normal_z = 0;
            end
            send_ray(ray, draw_gap(send_burst));
         end
      end

      settle();
      if (tracker.fails == 0 && tracker.pending_points.size() == 0)
         $display("ray_plane_intersect: match");
      else
         $display("ray_plane_intersect: mismatch");
      $finish;
   end

endmodule
